FILE: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg - shared definitions of the block buffer cache
// Command and action codes, slot status codes, sizes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int NUM_SLOTS  = 4;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CMD_W      = 3;
   localparam int BLK_W      = 16;
   localparam int ACT_W      = 2;
   localparam int SLOT_OUT_W = 4;
   localparam int AGE_W      = 32;
   localparam int STAT_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BLK_W-1:0] MAX_BLOCK_RESET = 16'd1024;
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_BLOCK = '0;

   localparam logic [CMD_W-1:0] CMD_BUFFER = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SAVE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EMPTY  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd5;

   localparam logic [ACT_W-1:0] ACT_DONE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_GRANT = 2'd3;

   localparam logic [STAT_W-1:0] ST_UNREAD = 2'd0;
   localparam logic [STAT_W-1:0] ST_VALID  = 2'd1;
   localparam logic [STAT_W-1:0] ST_DIRTY  = 2'd3;

   typedef enum logic [2:0] {
      EM_ERROR,
      EM_WB_VICTIM,
      EM_READ,
      EM_GRANT,
      EM_WB_SCAN,
      EM_DONE
   } emit_kind_type;

   typedef struct packed {
      logic          start;   // latch the accepted beat, restart the scan
      logic          step;    // lookup compare at the scan index
      logic          adv;     // move the scan index on
      logic          emit;    // load the output register
      emit_kind_type kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             blk_ok;
      logic             tag_hit;
      logic             idx_last;
      logic             dirty_now;
      logic             victim_dirty;
      logic             out_free;
   } dp_status_type;

endpackage

FILE: rtl/bbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbc_ctrl - command sequencer of the block buffer cache
// Walks each command through range check, slot scan and result emission,
// steering the datapath by command bundle.
// ----------------------------------------------------------------------------
module bbc_ctrl
   import bbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_WB,
      S_READ,
      S_GRANT,
      S_SAVE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      err_ff, err_in;    // finish with an error beat

   always_comb begin
      state_in  = state_ff;
      err_in    = err_ff;
      cmd       = '0;
      cmd.kind  = EM_DONE;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            err_in = 1'b0;
            if (sts.command inside {CMD_BUFFER, CMD_BLOCK}) begin
               if (sts.blk_ok) begin
                  state_in = S_SCAN;
               end else begin
                  err_in   = 1'b1;
                  state_in = S_FINISH;
               end
            end else if (sts.command inside {CMD_SAVE, CMD_FLUSH}) begin
               state_in = S_SAVE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (sts.tag_hit) begin
               state_in = S_GRANT;
            end else if (sts.idx_last) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (!sts.victim_dirty) begin
               state_in = S_READ;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EM_WB_VICTIM;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EM_READ;
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EM_GRANT;
               state_in = S_IDLE;
            end
         end
         S_SAVE: begin
            // a dirty slot holds the scan until its write-back beat goes out
            if (!sts.dirty_now || sts.out_free) begin
               cmd.adv = 1'b1;
               if (sts.dirty_now) begin
                  cmd.emit = 1'b1;
                  cmd.kind = EM_WB_SCAN;
               end
               if (sts.idx_last) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = err_ff ? EM_ERROR : EM_DONE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == EM_GRANT) |=> state_ff == S_IDLE)
      else $error("grant beat not followed by return to idle");

   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == S_CHECK && !req_ready))
      else $error("accepted command did not enter the range check");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == EM_READ) |-> $past(state_ff) != S_IDLE)
      else $error("read beat without a preceding scan");

endmodule

FILE: rtl/bbc_dp.sv
// ----------------------------------------------------------------------------
// bbc_dp - slot store and result register of the block buffer cache
// Holds tags, age stamps and statuses of the slots, the age counter, the
// scan index with the running victim, and the output register.
// ----------------------------------------------------------------------------
module bbc_dp
   import bbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [BLK_W-1:0]      req_block_number,
   input  logic [BLK_W-1:0]      max_block,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ACT_W-1:0]      rsp_action,
   output logic [BLK_W-1:0]      rsp_block_id,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic                  rsp_error,
   output logic                  rsp_last
);

   logic [BLK_W-1:0]  tag_ff    [NUM_SLOTS];
   logic [BLK_W-1:0]  tag_in    [NUM_SLOTS];
   logic [AGE_W-1:0]  stamp_ff  [NUM_SLOTS];
   logic [AGE_W-1:0]  stamp_in  [NUM_SLOTS];
   logic [STAT_W-1:0] status_ff [NUM_SLOTS];
   logic [STAT_W-1:0] status_in [NUM_SLOTS];

   logic [AGE_W-1:0]      age_ff, age_in;
   logic [SLOT_OUT_W-1:0] current_ff, current_in;

   logic [CMD_W-1:0]  command_ff, command_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] victim_ff, victim_in;
   logic              hit_ff, hit_in;
   logic [AGE_W-1:0]  best_stamp_ff, best_stamp_in;
   logic [BLK_W-1:0]  best_tag_ff, best_tag_in;
   logic [STAT_W-1:0] best_status_ff, best_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]      action_ff, action_in;
   logic [BLK_W-1:0]      block_id_ff, block_id_in;
   logic [SLOT_OUT_W-1:0] slot_ff, slot_in;
   logic                  error_ff, error_in;
   logic                  last_ff, last_in;

   logic [AGE_W-1:0] age_plus;
   logic             out_free;

   assign age_plus = age_ff + AGE_W'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sts.command      = command_ff;
   assign sts.blk_ok       = (blk_ff != '0) && (blk_ff <= max_block);
   assign sts.tag_hit      = (tag_ff[idx_ff] == blk_ff);
   assign sts.idx_last     = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
   assign sts.dirty_now    = (status_ff[idx_ff] == ST_DIRTY);
   assign sts.victim_dirty = (best_status_ff == ST_DIRTY);
   assign sts.out_free     = out_free;

   always_comb begin
      tag_in         = tag_ff;
      stamp_in       = stamp_ff;
      status_in      = status_ff;
      age_in         = age_ff;
      current_in     = current_ff;
      command_in     = command_ff;
      blk_in         = blk_ff;
      idx_in         = idx_ff;
      victim_in      = victim_ff;
      hit_in         = hit_ff;
      best_stamp_in  = best_stamp_ff;
      best_tag_in    = best_tag_ff;
      best_status_in = best_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      action_in      = action_ff;
      block_id_in    = block_id_ff;
      slot_in        = slot_ff;
      error_in       = error_ff;
      last_in        = last_ff;

      if (cmd.start) begin
         command_in = req_command;
         blk_in     = req_block_number;
         idx_in     = '0;
         hit_in     = 1'b0;
      end

      // one slot per cycle: first tag match wins, else track the oldest stamp
      if (cmd.step) begin
         if (tag_ff[idx_ff] == blk_ff) begin
            hit_in         = 1'b1;
            victim_in      = idx_ff;
            best_status_in = status_ff[idx_ff];
         end else begin
            if (idx_ff == '0 || best_stamp_ff > stamp_ff[idx_ff]) begin
               victim_in      = idx_ff;
               best_stamp_in  = stamp_ff[idx_ff];
               best_tag_in    = tag_ff[idx_ff];
               best_status_in = status_ff[idx_ff];
            end
            idx_in = idx_ff + SLOT_W'(1);
         end
      end

      if (cmd.adv) begin
         idx_in = idx_ff + SLOT_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         action_in    = ACT_DONE;
         block_id_in  = '0;
         slot_in      = '0;
         error_in     = 1'b0;
         last_in      = 1'b0;
         case (cmd.kind)
            EM_ERROR: begin
               block_id_in = blk_ff;
               error_in    = 1'b1;
               last_in     = 1'b1;
            end
            EM_WB_VICTIM: begin
               action_in   = ACT_WRITE;
               block_id_in = best_tag_ff;
               slot_in     = SLOT_OUT_W'(victim_ff);
            end
            EM_READ: begin
               action_in   = ACT_READ;
               block_id_in = blk_ff;
               slot_in     = SLOT_OUT_W'(victim_ff);
               // install the new block in the victim slot
               status_in[victim_ff] = (command_ff == CMD_BLOCK) ? ST_VALID : ST_UNREAD;
               tag_in[victim_ff]    = blk_ff;
               stamp_in[victim_ff]  = age_plus;
               age_in               = age_plus;
               current_in           = SLOT_OUT_W'(victim_ff);
            end
            EM_GRANT: begin
               action_in   = ACT_GRANT;
               block_id_in = blk_ff;
               slot_in     = SLOT_OUT_W'(victim_ff);
               last_in     = 1'b1;
               if (hit_ff) begin
                  stamp_in[victim_ff] = age_plus;
                  age_in              = age_plus;
                  current_in          = SLOT_OUT_W'(victim_ff);
                  if (command_ff == CMD_BLOCK && best_status_ff == ST_UNREAD) begin
                     status_in[victim_ff] = ST_VALID;
                  end
               end
            end
            EM_WB_SCAN: begin
               action_in         = ACT_WRITE;
               block_id_in       = tag_ff[idx_ff];
               slot_in           = SLOT_OUT_W'(idx_ff);
               status_in[idx_ff] = ST_VALID;
            end
            EM_DONE: begin
               last_in = 1'b1;
               if (command_ff == CMD_UPDATE) begin
                  if ({1'b0, current_ff} < (SLOT_OUT_W + 1)'(NUM_SLOTS)) begin
                     status_in[current_ff[SLOT_W-1:0]] = ST_DIRTY;
                  end
               end else if (command_ff inside {CMD_EMPTY, CMD_FLUSH}) begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     tag_in[i]    = '0;
                     stamp_in[i]  = '0;
                     status_in[i] = ST_UNREAD;
                  end
                  age_in     = '0;
                  current_in = '0;
               end
            end
            default: begin
               last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_ff[i]    <= '0;
            stamp_ff[i]  <= '0;
            status_ff[i] <= ST_UNREAD;
         end
         age_ff       <= '0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_ff       <= tag_in;
         stamp_ff     <= stamp_in;
         status_ff    <= status_in;
         age_ff       <= age_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff     <= command_in;
      blk_ff         <= blk_in;
      idx_ff         <= idx_in;
      victim_ff      <= victim_in;
      hit_ff         <= hit_in;
      best_stamp_ff  <= best_stamp_in;
      best_tag_ff    <= best_tag_in;
      best_status_ff <= best_status_in;
      action_ff      <= action_in;
      block_id_ff    <= block_id_in;
      slot_ff        <= slot_in;
      error_ff       <= error_in;
      last_ff        <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_action   = action_ff;
   assign rsp_block_id = block_id_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_error    = error_ff;
   assign rsp_last     = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded over a beat not yet taken");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && error_ff) |-> (last_ff && action_ff == ACT_DONE))
      else $error("error beat is not a final done beat");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == EM_READ) |=> age_ff == $past(age_plus))
      else $error("age counter not advanced on block install");

endmodule

FILE: rtl/block_buffer_cache_lru.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru - LRU write-back block buffer cache manager
// Tracks which storage block sits in each of NUM_SLOTS buffers and issues
// write-back, read and grant beats for buffer, block, update, save, empty
// and flush commands.
//
// Commands enter on the req_ channel (valid/ready), one at a time; the
// block is ready again once the final beat of a command is in the output
// register, so the next command may be taken while that beat still waits.
// Each command yields one to five beats on the rsp_ channel, the last one
// flagged by rsp_last. Update, empty and out-of-range commands end after
// the range check; a lookup walks the slots one per cycle and grants at the
// first hit, and a miss first emits a write-back beat for a dirty victim and
// a read beat. Save and flush walk the slots one per cycle, a dirty slot
// waiting until its write-back beat is loaded. The next command can be taken
// at the earliest in the cycle after the final beat is loaded.
// A stalled rsp_ready holds the output register, and the sequencer waits at any beat to load.
// Reset clears the cache and the age counter and sets max_block to 1024.
// max_block sits at address 0 of the csr_ port; write it only when idle.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru
   import bbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [BLK_W-1:0]      req_block_number,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ACT_W-1:0]      rsp_action,
   output logic [BLK_W-1:0]      rsp_block_id,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic                  rsp_error,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BLK_W-1:0] max_block_ff, max_block_in;
   logic             reg_sel;
   ctrl_cmd_type     cmd;
   dp_status_type    sts;

   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_MAX_BLOCK);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(max_block_ff) : '0;

   always_comb begin
      max_block_in = max_block_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         max_block_in = csr_pwdata[BLK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_block_ff <= MAX_BLOCK_RESET;
      end else begin
         max_block_ff <= max_block_in;
      end
   end

   bbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_block_number (req_block_number),
      .max_block        (max_block_ff),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_block_id     (rsp_block_id),
      .rsp_slot         (rsp_slot),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

endmodule
